FILE: rtl/tpf_pkg.sv
// Shared types, constants and the distance compare for the trajectory proximity filter.
// Used by every file of the block; depends on nothing.
`default_nettype none

package tpf_pkg;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 16;
    localparam int R2_W    = 2 * RAD_W;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 1;

    localparam int DEF_MAX_PATH_POINTS = 256;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_TEST   = 2'd2;

    // One request as it travels down the row of cells.
    typedef struct packed {
        logic               vld;
        logic [1:0]         action;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_item;

    // Squares produced by one cell, checked by the next one, plus the running hit flag.
    typedef struct packed {
        logic            sq_vld;
        logic            hit;
        logic [SQ_W-1:0] sqx;
        logic [SQ_W-1:0] sqy;
    } t_cmp;

    function automatic logic in_radius(input logic [SQ_W-1:0] sqx,
                                       input logic [SQ_W-1:0] sqy,
                                       input logic [R2_W-1:0] r2);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(sqx) + SUM_W'(sqy);
        return sum < SUM_W'(r2);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tpf_if.sv
// Handshake channels of the trajectory proximity filter: point requests, kept points, radius.
// Depends on tpf_pkg for the field widths.
`default_nettype none

interface tpf_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic signed [tpf_pkg::COORD_W-1:0] pos_x;
    logic signed [tpf_pkg::COORD_W-1:0] pos_y;

    modport source(output valid, action, pos_x, pos_y, input ready);
    modport sink(input valid, action, pos_x, pos_y, output ready);
endinterface

interface tpf_out_if;
    logic                        valid;
    logic                        ready;
    logic signed [tpf_pkg::COORD_W-1:0] kept_x;
    logic signed [tpf_pkg::COORD_W-1:0] kept_y;

    modport source(output valid, kept_x, kept_y, input ready);
    modport sink(input valid, kept_x, kept_y, output ready);
endinterface

interface tpf_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [tpf_pkg::RAD_W-1:0] radius;

    modport source(output valid, radius, input ready);
    modport sink(input valid, radius, output ready);
endinterface

`default_nettype wire

FILE: rtl/tpf_cell.sv
// One cell of the filter row: holds one trajectory point, squares the distance to a passing
// test point and checks the squares handed over by the previous cell. Depends on tpf_pkg.
`default_nettype none

module tpf_cell #(
    parameter int IDX_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire  [tpf_pkg::R2_W-1:0]      i_r2,
    input  wire  tpf_pkg::t_item          i_item,
    input  wire  [IDX_W-1:0]              i_tgt,
    input  wire  tpf_pkg::t_cmp           i_cmp,
    output tpf_pkg::t_item                o_item,
    output logic [IDX_W-1:0]              o_tgt,
    output tpf_pkg::t_cmp                 o_cmp
);

    localparam int CW = tpf_pkg::COORD_W;
    localparam int PW = 2 * CW + 2;

    logic             r_vld;
    logic [1:0]       r_action;
    logic [CW-1:0]    r_x;
    logic [CW-1:0]    r_y;
    tpf_pkg::t_cmp    r_cmp;
    logic [IDX_W-1:0] r_tgt;
    logic             r_pt_valid;
    logic [CW-1:0]    r_px;
    logic [CW-1:0]    r_py;

    logic signed [CW:0]     dx;
    logic signed [CW:0]     dy;
    logic signed [2*CW+1:0] prod_x;
    logic signed [2*CW+1:0] prod_y;
    logic                   is_test;
    logic                   is_mine;

    assign dx      = $signed({r_px[CW-1], r_px}) - $signed({i_item.x[CW-1], i_item.x});
    assign dy      = $signed({r_py[CW-1], r_py}) - $signed({i_item.y[CW-1], i_item.y});
    assign prod_x  = PW'(dx) * PW'(dx);
    assign prod_y  = PW'(dy) * PW'(dy);
    assign is_test = i_item.vld && (i_item.action == tpf_pkg::ACT_TEST);
    assign is_mine = i_item.vld && (i_item.action == tpf_pkg::ACT_APPEND)
                     && (i_tgt == IDX_W'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_pt_valid <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_item.vld;
            if (i_item.vld) begin
                case (i_item.action)
                    tpf_pkg::ACT_CLEAR: begin
                        r_pt_valid <= 1'b0;
                    end
                    tpf_pkg::ACT_APPEND: begin
                        if (is_mine) begin
                            r_pt_valid <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // The hit flag folds in the previous cell's squares, so the compare lags the squaring
    // by one cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_action      <= i_item.action;
            r_x           <= i_item.x;
            r_y           <= i_item.y;
            r_tgt         <= i_tgt;
            r_cmp.hit     <= i_cmp.hit
                             || (i_cmp.sq_vld && tpf_pkg::in_radius(i_cmp.sqx, i_cmp.sqy, i_r2));
            r_cmp.sq_vld  <= is_test && r_pt_valid;
            r_cmp.sqx     <= prod_x[tpf_pkg::SQ_W-1:0];
            r_cmp.sqy     <= prod_y[tpf_pkg::SQ_W-1:0];
            if (is_mine) begin
                r_px <= i_item.x;
                r_py <= i_item.y;
            end
        end
    end

    assign o_item = {r_vld, r_action, r_x, r_y};
    assign o_tgt  = r_tgt;
    assign o_cmp  = r_cmp;

endmodule

`default_nettype wire

FILE: rtl/tpf_chain.sv
// Row of tpf_cell instances, one per trajectory point slot, each feeding its neighbor.
// Depends on tpf_pkg and tpf_cell.
`default_nettype none

module tpf_chain #(
    parameter int   MAX_PATH_POINTS = tpf_pkg::DEF_MAX_PATH_POINTS,
    localparam int  IDX_W = (MAX_PATH_POINTS > 1) ? $clog2(MAX_PATH_POINTS) : 1
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire  [tpf_pkg::R2_W-1:0]  i_r2,
    input  wire  tpf_pkg::t_item      i_item,
    input  wire  [IDX_W-1:0]          i_tgt,
    output tpf_pkg::t_item            o_item,
    output tpf_pkg::t_cmp             o_cmp
);

    tpf_pkg::t_item   item_s [0:MAX_PATH_POINTS];
    tpf_pkg::t_cmp    cmp_s  [0:MAX_PATH_POINTS];
    logic [IDX_W-1:0] tgt_s  [0:MAX_PATH_POINTS];

    assign item_s[0] = i_item;
    assign tgt_s[0]  = i_tgt;
    assign cmp_s[0]  = '0;

    for (genvar g = 0; g < MAX_PATH_POINTS; g++) begin : g_cell
        tpf_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_r2    (i_r2),
            .i_item  (item_s[g]),
            .i_tgt   (tgt_s[g]),
            .i_cmp   (cmp_s[g]),
            .o_item  (item_s[g+1]),
            .o_tgt   (tgt_s[g+1]),
            .o_cmp   (cmp_s[g+1])
        );
    end

    assign o_item = item_s[MAX_PATH_POINTS];
    assign o_cmp  = cmp_s[MAX_PATH_POINTS];

endmodule

`default_nettype wire

FILE: rtl/trajectory_proximity_point_filter.sv
// Trajectory proximity point filter: after its request is accepted, a kept point passes every
// cell of the row, one register per cell, and then the output register.
// Throughput is one request per cycle; input stalls only while two kept points wait unread.
// Synchronous active-low reset clears the point count, the radius, its square, both output
// slot flags and every cell's valid flags; the stored coordinates are not cleared.
// Depends on tpf_pkg, tpf_if and tpf_chain.
`default_nettype none

module trajectory_proximity_point_filter #(
    parameter int MAX_PATH_POINTS = tpf_pkg::DEF_MAX_PATH_POINTS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tpf_in_if.sink       i_pt,
    tpf_cfg_if.sink      i_cfg,
    tpf_out_if.source    o_kept
);

    localparam int IDX_W = (MAX_PATH_POINTS > 1) ? $clog2(MAX_PATH_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_PATH_POINTS + 1);
    localparam int CW    = tpf_pkg::COORD_W;

    logic [tpf_pkg::RAD_W-1:0] r_radius;
    logic [tpf_pkg::R2_W-1:0]  r_r2;
    logic [CNT_W-1:0]          r_count;
    logic                      r_out_valid;
    logic [CW-1:0]             r_out_x;
    logic [CW-1:0]             r_out_y;
    logic                      r_skid_valid;
    logic [CW-1:0]             r_skid_x;
    logic [CW-1:0]             r_skid_y;

    logic           en;
    logic           acc;
    logic           full;
    logic           keep;
    logic           pop;
    logic           push;
    logic           last_hit;
    tpf_pkg::t_item item_in;
    tpf_pkg::t_item item_last;
    tpf_pkg::t_cmp  cmp_last;

    // The row moves whenever the second output slot is free.
    assign en          = !r_skid_valid;
    assign i_pt.ready  = en;
    assign i_cfg.ready = 1'b1;
    assign acc         = i_pt.valid && en;
    assign full        = (r_count == CNT_W'(MAX_PATH_POINTS));

    // Appends to a full table and the unused action code never enter the row.
    assign keep = (i_pt.action == tpf_pkg::ACT_CLEAR) || (i_pt.action == tpf_pkg::ACT_TEST)
                  || ((i_pt.action == tpf_pkg::ACT_APPEND) && !full);

    assign item_in.vld    = acc && keep;
    assign item_in.action = i_pt.action;
    assign item_in.x      = i_pt.pos_x;
    assign item_in.y      = i_pt.pos_y;

    tpf_chain #(
        .MAX_PATH_POINTS (MAX_PATH_POINTS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_r2    (r_r2),
        .i_item  (item_in),
        .i_tgt   (r_count[IDX_W-1:0]),
        .o_item  (item_last),
        .o_cmp   (cmp_last)
    );

    assign last_hit = cmp_last.hit
                      || (cmp_last.sq_vld
                          && tpf_pkg::in_radius(cmp_last.sqx, cmp_last.sqy, r_r2));
    assign push     = en && item_last.vld && (item_last.action == tpf_pkg::ACT_TEST)
                      && last_hit;
    assign pop      = r_out_valid && o_kept.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= '0;
            r_r2         <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_radius <= i_cfg.radius;
            end
            r_r2 <= tpf_pkg::R2_W'(r_radius) * tpf_pkg::R2_W'(r_radius);
            if (acc) begin
                case (i_pt.action)
                    tpf_pkg::ACT_CLEAR: begin
                        r_count <= '0;
                    end
                    tpf_pkg::ACT_APPEND: begin
                        if (!full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (!r_out_valid || pop) begin
                r_out_valid  <= r_skid_valid || push;
                r_skid_valid <= 1'b0;
            end else if (push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_x <= r_skid_x;
                r_out_y <= r_skid_y;
            end else begin
                r_out_x <= item_last.x;
                r_out_y <= item_last.y;
            end
        end else if (push) begin
            r_skid_x <= item_last.x;
            r_skid_y <= item_last.y;
        end
    end

    assign o_kept.valid  = r_out_valid;
    assign o_kept.kept_x = r_out_x;
    assign o_kept.kept_y = r_out_y;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PATH_POINTS))
        else $error("point count above table size");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("second output slot filled while the first is empty");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready && (i_pt.action == tpf_pkg::ACT_CLEAR))
        |=> (r_count == '0))
        else $error("clear request did not empty the table");
`endif

endmodule

`default_nettype wire
